// File: hdl/bmpfb_pkg.sv
// ----------------------------------------------------------------------------
// bmpfb_pkg
// Shared types and constants of the 24-bit BMP to framebuffer writer.
// ----------------------------------------------------------------------------
package bmpfb_pkg;

  // Default parameter values
  localparam int MAX_DIM_DEF         = 4096;
  localparam int MAX_DATA_OFFSET_DEF = 65535;

  // Fixed field widths
  localparam int KIND_W     = 3;
  localparam int ADDR_W     = 28;
  localparam int PIX_W      = 24;
  localparam int PITCH_W    = 16;
  localparam int SCR_W      = 13;
  localparam int PLACE_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Header layout
  localparam int HDR_LEN  = 54;
  localparam int OFS_POS  = 10;
  localparam int WID_POS  = 18;
  localparam int HGT_POS  = 22;
  localparam int BPP_POS  = 28;
  localparam logic [7:0]  CH_B   = 8'h42;
  localparam logic [7:0]  CH_M   = 8'h4D;
  localparam logic [15:0] BPP_24 = 16'd24;

  // Parser phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_PIXELS = 3'd2;
  localparam logic [2:0] PH_DONE   = 3'd3;
  localparam logic [2:0] PH_ERROR  = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] RK_PIXEL   = 3'd0;
  localparam logic [KIND_W-1:0] RK_DONE    = 3'd1;
  localparam logic [KIND_W-1:0] RK_NOT_BMP = 3'd2;
  localparam logic [KIND_W-1:0] RK_DEPTH   = 3'd3;
  localparam logic [KIND_W-1:0] RK_SIZE    = 3'd4;
  localparam logic [KIND_W-1:0] RK_TRUNC   = 3'd5;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;
  localparam logic [PITCH_W-1:0]   PITCH_RST  = 16'd7680;
  localparam logic [SCR_W-1:0]     SCR_W_RST  = 13'd1920;
  localparam logic [SCR_W-1:0]     SCR_H_RST  = 13'd1080;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [ADDR_W-1:0] address;
    logic [PIX_W-1:0]  pixel_data;
    logic              last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [PITCH_W-1:0] line_pitch;
    logic [SCR_W-1:0]   screen_width;
    logic [SCR_W-1:0]   screen_height;
  } cfg_t;

  // Up to two results produced by one word
  typedef struct packed {
    logic [1:0] count;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

endpackage

// File: hdl/bmpfb_core.sv
// ----------------------------------------------------------------------------
// bmpfb_core
// Header parser, offset skip, row/pixel walker; one word per cycle on go.
// ----------------------------------------------------------------------------
module bmpfb_core #(
  parameter int MAX_DIM         = bmpfb_pkg::MAX_DIM_DEF,
  parameter int MAX_DATA_OFFSET = bmpfb_pkg::MAX_DATA_OFFSET_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  bmpfb_pkg::in_item_t item,
  input  bmpfb_pkg::cfg_t     cfg,
  output bmpfb_pkg::push_t    push
);
  import bmpfb_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int SX_W   = ((DIM_W > SCR_W) ? DIM_W : SCR_W) + 1;
  localparam int ROW_W  = $clog2(3 * MAX_DIM + 4);
  localparam int OFS_W  = $clog2(MAX_DATA_OFFSET + 1);
  localparam int PROD_W = SX_W + PITCH_W;

  logic [2:0]         phase, phase_next;
  logic [OFS_W-1:0]   byte_position, byte_position_next;
  logic [OFS_W-1:0]   data_start, data_start_next;
  logic [31:0]        hdr_offset, hdr_offset_next;
  logic [31:0]        hdr_width, hdr_width_next;
  logic [31:0]        hdr_height, hdr_height_next;
  logic [15:0]        bits_per_pixel, bits_per_pixel_next;
  logic               sig_ok, sig_ok_next;
  logic [DIM_W-1:0]   image_width, image_width_next;
  logic [DIM_W-1:0]   image_height, image_height_next;
  logic [ROW_W-1:0]   row_last, row_last_next;
  logic [ROW_W-1:0]   row_byte_index, row_byte_index_next;
  logic [DIM_W-1:0]   file_row, file_row_next;
  logic [DIM_W-1:0]   col, col_next;
  logic [1:0]         chan, chan_next;
  logic [SX_W-1:0]    sx, sx_next;
  logic [SX_W-1:0]    sy, sy_next;
  logic [PLACE_W-1:0] place_x, place_x_next;
  logic [7:0]         blue_hold, blue_hold_next;
  logic [7:0]         green_hold, green_hold_next;

  logic [7:0]         b;
  logic [1:0]         ofs_lane, wid_lane, hgt_lane;
  logic               size_bad;
  logic [SX_W-1:0]    w_s, h_s, sw_s, sh_s;
  logic [PLACE_W-1:0] cx, cy;
  logic [ROW_W-1:0]   w3, row_len;
  logic [OFS_W-1:0]   hdr_ofs_cut, skip_next;
  logic [PROD_W-1:0]  row_base, addr_sum;
  logic               emit_px, emit_st;
  logic [KIND_W-1:0]  st_kind;
  out_item_t          px_item, st_item;

  assign b = item.byte_value;

  assign ofs_lane = 2'(byte_position - OFS_W'(OFS_POS));
  assign wid_lane = 2'(byte_position - OFS_W'(WID_POS));
  assign hgt_lane = 2'(byte_position - OFS_W'(HGT_POS));

  assign size_bad = (hdr_width == 32'd0) || (hdr_width > 32'(MAX_DIM)) ||
                    (hdr_height == 32'd0) || (hdr_height > 32'(MAX_DIM)) ||
                    (hdr_offset > 32'(MAX_DATA_OFFSET));

  // Placement at header end: center only when smaller in both axes
  assign w_s  = SX_W'(hdr_width[DIM_W-1:0]);
  assign h_s  = SX_W'(hdr_height[DIM_W-1:0]);
  assign sw_s = SX_W'(cfg.screen_width);
  assign sh_s = SX_W'(cfg.screen_height);
  always_comb begin
    cx = '0;
    cy = '0;
    if (w_s < sw_s && h_s < sh_s) begin
      cx = PLACE_W'((sw_s - w_s) >> 1);
      cy = PLACE_W'((sh_s - h_s) >> 1);
    end
  end

  // Padded row length: round width*3 up to a multiple of four
  assign w3      = (ROW_W'(hdr_width[DIM_W-1:0]) << 1) + ROW_W'(hdr_width[DIM_W-1:0]);
  assign row_len = (w3 + ROW_W'(3)) & ~ROW_W'(3);

  assign hdr_ofs_cut = (hdr_offset < 32'(HDR_LEN)) ? OFS_W'(HDR_LEN)
                                                   : hdr_offset[OFS_W-1:0];
  assign skip_next   = byte_position + OFS_W'(1);

  assign row_base = PROD_W'(sy) * PROD_W'(cfg.line_pitch);
  assign addr_sum = row_base + (PROD_W'(sx) << 2);

  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    data_start_next     = data_start;
    hdr_offset_next     = hdr_offset;
    hdr_width_next      = hdr_width;
    hdr_height_next     = hdr_height;
    bits_per_pixel_next = bits_per_pixel;
    sig_ok_next         = sig_ok;
    image_width_next    = image_width;
    image_height_next   = image_height;
    row_last_next       = row_last;
    row_byte_index_next = row_byte_index;
    file_row_next       = file_row;
    col_next            = col;
    chan_next           = chan;
    sx_next             = sx;
    sy_next             = sy;
    place_x_next        = place_x;
    blue_hold_next      = blue_hold;
    green_hold_next     = green_hold;
    emit_px             = 1'b0;
    emit_st             = 1'b0;
    st_kind             = RK_DONE;

    if (go) begin
      if (item.kind) begin
        if (phase == PH_HEADER || phase == PH_SKIP || phase == PH_PIXELS) begin
          emit_st = 1'b1;
          st_kind = RK_TRUNC;
        end
        phase_next         = PH_HEADER;
        byte_position_next = '0;
      end else begin
        case (phase)
          PH_HEADER: begin
            if (byte_position == OFS_W'(0)) begin
              sig_ok_next = (b == CH_B);
            end else if (byte_position == OFS_W'(1)) begin
              sig_ok_next = sig_ok && (b == CH_M);
            end else if (byte_position >= OFS_W'(OFS_POS) &&
                         byte_position <= OFS_W'(OFS_POS + 3)) begin
              hdr_offset_next[{ofs_lane, 3'b000} +: 8] = b;
            end else if (byte_position >= OFS_W'(WID_POS) &&
                         byte_position <= OFS_W'(WID_POS + 3)) begin
              hdr_width_next[{wid_lane, 3'b000} +: 8] = b;
            end else if (byte_position >= OFS_W'(HGT_POS) &&
                         byte_position <= OFS_W'(HGT_POS + 3)) begin
              hdr_height_next[{hgt_lane, 3'b000} +: 8] = b;
            end else if (byte_position == OFS_W'(BPP_POS)) begin
              bits_per_pixel_next[7:0] = b;
            end else if (byte_position == OFS_W'(BPP_POS + 1)) begin
              bits_per_pixel_next[15:8] = b;
            end
            byte_position_next = skip_next;
            if (byte_position == OFS_W'(HDR_LEN - 1)) begin
              if (!sig_ok) begin
                phase_next = PH_ERROR;
                emit_st    = 1'b1;
                st_kind    = RK_NOT_BMP;
              end else if (bits_per_pixel != BPP_24) begin
                phase_next = PH_ERROR;
                emit_st    = 1'b1;
                st_kind    = RK_DEPTH;
              end else if (size_bad) begin
                phase_next = PH_ERROR;
                emit_st    = 1'b1;
                st_kind    = RK_SIZE;
              end else begin
                image_width_next    = hdr_width[DIM_W-1:0];
                image_height_next   = hdr_height[DIM_W-1:0];
                data_start_next     = hdr_ofs_cut;
                row_last_next       = row_len - ROW_W'(1);
                row_byte_index_next = '0;
                file_row_next       = '0;
                col_next            = '0;
                chan_next           = 2'd0;
                place_x_next        = cx;
                sx_next             = SX_W'(cx);
                sy_next             = SX_W'(cy) + h_s - SX_W'(1);
                phase_next = (hdr_ofs_cut == OFS_W'(HDR_LEN)) ? PH_PIXELS : PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            byte_position_next = skip_next;
            if (skip_next >= data_start) begin
              phase_next = PH_PIXELS;
            end
          end
          PH_PIXELS: begin
            if (col < image_width) begin
              case (chan)
                2'd0: begin
                  blue_hold_next = b;
                  chan_next      = 2'd1;
                end
                2'd1: begin
                  green_hold_next = b;
                  chan_next       = 2'd2;
                end
                default: begin
                  emit_px   = (sx < sw_s) && (sy < sh_s);
                  chan_next = 2'd0;
                  col_next  = col + DIM_W'(1);
                  sx_next   = sx + SX_W'(1);
                end
              endcase
            end
            if (row_byte_index == row_last) begin
              // next file row is one screen row up
              row_byte_index_next = '0;
              file_row_next       = file_row + DIM_W'(1);
              col_next            = '0;
              chan_next           = 2'd0;
              sx_next             = SX_W'(place_x);
              sy_next             = sy - SX_W'(1);
              if (file_row == image_height - DIM_W'(1)) begin
                phase_next = PH_DONE;
                emit_st    = 1'b1;
                st_kind    = RK_DONE;
              end
            end else begin
              row_byte_index_next = row_byte_index + ROW_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    px_item.result_kind = RK_PIXEL;
    px_item.address     = ADDR_W'(addr_sum);
    px_item.pixel_data  = {b, green_hold, blue_hold};
    px_item.last_of_run = !emit_st;
    st_item.result_kind = st_kind;
    st_item.address     = '0;
    st_item.pixel_data  = '0;
    st_item.last_of_run = 1'b1;
    push.count = 2'(emit_px) + 2'(emit_st);
    push.item0 = emit_px ? px_item : st_item;
    push.item1 = st_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      byte_position <= '0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    data_start     <= data_start_next;
    hdr_offset     <= hdr_offset_next;
    hdr_width      <= hdr_width_next;
    hdr_height     <= hdr_height_next;
    bits_per_pixel <= bits_per_pixel_next;
    sig_ok         <= sig_ok_next;
    image_width    <= image_width_next;
    image_height   <= image_height_next;
    row_last       <= row_last_next;
    row_byte_index <= row_byte_index_next;
    file_row       <= file_row_next;
    col            <= col_next;
    chan           <= chan_next;
    sx             <= sx_next;
    sy             <= sy_next;
    place_x        <= place_x_next;
    blue_hold      <= blue_hold_next;
    green_hold     <= green_hold_next;
  end

endmodule

// File: hdl/bmpfb_outq.sv
// ----------------------------------------------------------------------------
// bmpfb_outq
// Three-entry result queue; up to two in a cycle, one out when not stalled.
// ----------------------------------------------------------------------------
module bmpfb_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  bmpfb_pkg::push_t     push,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bmpfb_pkg::out_item_t out_item
);
  import bmpfb_pkg::*;

  localparam int DEPTH = 3;

  out_item_t  q [DEPTH];
  out_item_t  q_next [DEPTH];
  logic [1:0] cnt, cnt_next;
  logic [1:0] fill;
  logic       pop;

  assign out_valid = (cnt != 2'd0);
  assign out_item  = q[0];
  assign pop       = out_valid && !out_stall;
  // a word may enter only when two slots are sure to be free
  assign room      = (cnt <= 2'd1);
  assign fill      = cnt - 2'(pop);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        q_next[i] = q[i + 1];
      end
    end
    if (push.count != 2'd0) begin
      q_next[fill] = push.item0;
    end
    if (push.count == 2'd2) begin
      q_next[fill + 2'd1] = push.item1;
    end
    cnt_next = fill + push.count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule

// File: hdl/bmp24_stream_to_framebuffer.sv
// ----------------------------------------------------------------------------
// bmp24_stream_to_framebuffer
// 24-bit BMP byte stream to XRGB8888 framebuffer write generator.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per file byte (kind 0) or an end-of-stream marker
//           (kind 1). A word is taken when in_valid is high and in_stall low.
//   out_* : pixel writes (address, pixel_data) and done/error/truncated
//           reports; last_of_run marks the last result of an input word.
//   cfg_* : line pitch and screen size, written by index while idle;
//           cfg_ready is always high.
// Throughput is one input word per cycle while out_stall stays low. The only
// word that makes two results is the last byte of the last row when it also
// closes a pixel; the output side then gives the two results one after the
// other and in_stall may rise. From input accept to the first result a word
// passes the input register and then the result queue. The address multiply
// (screen row times pitch) sits between those two registers.
// Reset clears the parser to header phase, empties both stages and loads
// the default pitch and screen size. When out_stall is held the three-entry
// result queue fills and in_stall rises; no result is dropped.
// ----------------------------------------------------------------------------
module bmp24_stream_to_framebuffer #(
  parameter int MAX_DIM         = bmpfb_pkg::MAX_DIM_DEF,
  parameter int MAX_DATA_OFFSET = bmpfb_pkg::MAX_DATA_OFFSET_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  bmpfb_pkg::in_item_t                  in_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output bmpfb_pkg::out_item_t                 out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bmpfb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmpfb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bmpfb_pkg::*;

  logic     in_full;
  in_item_t in_reg;
  logic     room;
  logic     advance;
  cfg_t     cfg;
  push_t    push;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && room;
  assign in_stall  = in_full && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_pitch    <= PITCH_RST;
      cfg.screen_width  <= SCR_W_RST;
      cfg.screen_height <= SCR_H_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LINE_PITCH:    cfg.line_pitch    <= cfg_data[PITCH_W-1:0];
        CFG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[SCR_W-1:0];
        CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  bmpfb_core #(
    .MAX_DIM         (MAX_DIM),
    .MAX_DATA_OFFSET (MAX_DATA_OFFSET)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .go   (advance),
    .item (in_reg),
    .cfg  (cfg),
    .push (push)
  );

  bmpfb_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: hdl/bmpfb_checker.sv
// ----------------------------------------------------------------------------
// bmpfb_checker
// Port-level checks of the BMP framebuffer writer, bound to the top level.
// ----------------------------------------------------------------------------
module bmpfb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input bmpfb_pkg::out_item_t              out_item
);
  import bmpfb_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or vanished");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.result_kind != RK_PIXEL |->
      out_item.address == '0 && out_item.pixel_data == '0)
    else $error("status result carries address or data");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.result_kind != RK_PIXEL |-> out_item.last_of_run)
    else $error("status result not marked last of run");

endmodule

bind bmp24_stream_to_framebuffer bmpfb_checker u_bmpfb_checker (.*);

// File: bench/bmp24_fb_checker.sv
// ----------------------------------------------------------------------------
// bmp24_fb_checker
// Watches the byte, result and register channels of the BMP framebuffer
// writer, parses each accepted byte into the framebuffer writes and reports it
// should produce, and compares every accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module bmp24_fb_checker #(
  parameter int MAX_DIM         = bmpfb_pkg::MAX_DIM_DEF,
  parameter int MAX_DATA_OFFSET = bmpfb_pkg::MAX_DATA_OFFSET_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  bmpfb_pkg::in_item_t              in_item,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  bmpfb_pkg::out_item_t             out_item,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [bmpfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmpfb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               failures,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bmpfb_pkg::*;

  // screen registers as the block holds them
  logic [PITCH_W-1:0] pitch_r;
  logic [SCR_W-1:0]   scr_w;
  logic [SCR_W-1:0]   scr_h;

  // file parse state
  logic [2:0]  ph;
  logic [15:0] pos;
  logic [15:0] data_start;
  logic [31:0] hdr_ofs;
  logic [31:0] hdr_wid;
  logic [31:0] hdr_hgt;
  logic [15:0] bpp;
  logic        sig_good;
  logic [12:0] img_w;
  logic [12:0] img_h;
  logic [14:0] row_idx;
  logic [12:0] file_row;
  logic [7:0]  blue_b;
  logic [7:0]  green_b;
  logic [11:0] org_x;
  logic [11:0] org_y;

  out_item_t due_results [$];
  out_item_t word_res [2];
  int        word_n;
  int        bad_count = 0;
  int        queued = 0;

  assign failures = bad_count;
  assign pending  = queued;

  task automatic forget_file();
    ph = PH_HEADER;
    pos = '0; data_start = '0;
    hdr_ofs = '0; hdr_wid = '0; hdr_hgt = '0; bpp = '0;
    sig_good = 1'b0;
    img_w = '0; img_h = '0;
    row_idx = '0; file_row = '0;
    blue_b = '0; green_b = '0;
    org_x = '0; org_y = '0;
  endtask

  task automatic note(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                      input logic [PIX_W-1:0] d);
    out_item_t r;
    r.result_kind = k;
    r.address     = a;
    r.pixel_data  = d;
    r.last_of_run = 1'b0;
    word_res[word_n] = r;
    word_n++;
  endtask

  task automatic take_header_byte(input logic [7:0] b);
    logic [15:0] p;
    logic [31:0] b32;
    p = pos;
    b32 = {24'd0, b};
    if (p == 16'd0) sig_good = (b == CH_B);
    else if (p == 16'd1) sig_good = sig_good && (b == CH_M);
    else if (p >= OFS_POS && p < OFS_POS + 4) hdr_ofs |= b32 << ((p - OFS_POS) * 8);
    else if (p >= WID_POS && p < WID_POS + 4) hdr_wid |= b32 << ((p - WID_POS) * 8);
    else if (p >= HGT_POS && p < HGT_POS + 4) hdr_hgt |= b32 << ((p - HGT_POS) * 8);
    else if (p >= BPP_POS && p < BPP_POS + 2) bpp |= 16'(b32 << ((p - BPP_POS) * 8));
    pos = p + 16'd1;
    if (p == 16'(HDR_LEN - 1)) begin
      // mark first, then depth, then sizes
      if (!sig_good) begin
        ph = PH_ERROR;
        note(RK_NOT_BMP, '0, '0);
      end else if (bpp != BPP_24) begin
        ph = PH_ERROR;
        note(RK_DEPTH, '0, '0);
      end else if (hdr_wid == 32'd0 || hdr_wid > MAX_DIM || hdr_hgt == 32'd0 ||
                   hdr_hgt > MAX_DIM || hdr_ofs > MAX_DATA_OFFSET) begin
        ph = PH_ERROR;
        note(RK_SIZE, '0, '0);
      end else begin
        img_w = hdr_wid[12:0];
        img_h = hdr_hgt[12:0];
        if (hdr_ofs < HDR_LEN) data_start = 16'(HDR_LEN);
        else data_start = hdr_ofs[15:0];
        if (img_w < scr_w && img_h < scr_h) begin
          org_x = 12'((scr_w - img_w) / 13'd2);
          org_y = 12'((scr_h - img_h) / 13'd2);
        end else begin
          org_x = '0;
          org_y = '0;
        end
        row_idx = '0;
        file_row = '0;
        ph = (data_start == 16'(HDR_LEN)) ? PH_PIXELS : PH_SKIP;
      end
    end
  endtask

  task automatic take_pixel_byte(input logic [7:0] b);
    logic [31:0] i;
    logic [31:0] span;
    logic [31:0] row_len;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [63:0] addr;
    i = {17'd0, row_idx};
    span = {19'd0, img_w} * 32'd3;
    row_len = (span + 32'd3) & ~32'd3;
    if (i < span) begin
      case (i % 32'd3)
        32'd0: blue_b = b;
        32'd1: green_b = b;
        default: begin
          // file rows run bottom-up
          sx = {20'd0, org_x} + i / 32'd3;
          sy = {20'd0, org_y} + {19'd0, img_h} - 32'd1 - {19'd0, file_row};
          if (sx < {19'd0, scr_w} && sy < {19'd0, scr_h}) begin
            addr = {32'd0, sy} * {48'd0, pitch_r} + {32'd0, sx} * 64'd4;
            note(RK_PIXEL, addr[ADDR_W-1:0], {b, green_b, blue_b});
          end
        end
      endcase
    end
    if (i + 32'd1 >= row_len) begin
      row_idx = '0;
      file_row = file_row + 13'd1;
      if (file_row >= img_h) begin
        ph = PH_DONE;
        note(RK_DONE, '0, '0);
      end
    end else begin
      row_idx = 15'(i + 32'd1);
    end
  endtask

  task automatic parse_file_byte(input in_item_t w);
    out_item_t r;
    word_n = 0;
    if (w.kind) begin
      if (ph == PH_HEADER || ph == PH_SKIP || ph == PH_PIXELS) note(RK_TRUNC, '0, '0);
      forget_file();
    end else begin
      case (ph)
        PH_HEADER: take_header_byte(w.byte_value);
        PH_SKIP: begin
          pos = pos + 16'd1;
          if (pos >= data_start) ph = PH_PIXELS;
        end
        PH_PIXELS: take_pixel_byte(w.byte_value);
        default: ;
      endcase
    end
    for (int k = 0; k < word_n; k++) begin
      r = word_res[k];
      r.last_of_run = (k == word_n - 1);
      due_results.push_back(r);
    end
  endtask

  task automatic compare_field(input string what, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      bad_count++;
      $display("%0t: %s expected %h got %h", $time, what, want, got);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (due_results.size() == 0) begin
      bad_count++;
      $display("%0t: result with nothing due, expected none got kind %0d address %h data %h",
               $time, got.result_kind, got.address, got.pixel_data);
    end else begin
      want = due_results.pop_front();
      compare_field("result_kind", ADDR_W'(want.result_kind), ADDR_W'(got.result_kind));
      compare_field("address", want.address, got.address);
      compare_field("pixel_data", ADDR_W'(want.pixel_data), ADDR_W'(got.pixel_data));
      compare_field("last_of_run", ADDR_W'(want.last_of_run), ADDR_W'(got.last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pitch_r = PITCH_RST;
      scr_w = SCR_W_RST;
      scr_h = SCR_H_RST;
      forget_file();
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result(out_item);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LINE_PITCH:    pitch_r = cfg_data;
          CFG_SCREEN_WIDTH:  scr_w = cfg_data[SCR_W-1:0];
          CFG_SCREEN_HEIGHT: scr_h = cfg_data[SCR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) parse_file_byte(in_item);
    end
    queued = due_results.size();
  end

endmodule

// File: bench/bmp24_stream_to_framebuffer_tb.sv
// ----------------------------------------------------------------------------
// bmp24_stream_to_framebuffer_tb
// Feeds BMP files byte by byte into the framebuffer writer: directed files for
// header errors, offsets, centring, clipping and the largest sizes, then
// random well-formed, truncated, corrupted and noise files under several
// screen settings, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module bmp24_stream_to_framebuffer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bmpfb_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    failures;
  int                    pending;

  bit         calm;
  logic [7:0] file_q [$];
  int         counted;

  bmp24_stream_to_framebuffer i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bmp24_fb_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: stall a random number of cycles, then take one word
  initial begin : sink
    int   n;
    logic seen;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      n = calm ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        seen = (out_valid === 1'b1);
        @(posedge clk);
      end while (!seen);
    end
  end

  task automatic put_word(input logic kind, input logic [7:0] b);
    int   gap;
    logic held;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= {kind, b};
    do begin
      @(negedge clk);
      held = (in_stall !== 1'b0);
      @(posedge clk);
    end while (held);
  endtask

  // drop valid and wait until every due result has come out
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    logic ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      ok = (cfg_ready === 1'b1);
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic set_screen(input logic [15:0] pitch, input logic [12:0] w,
                            input logic [12:0] h);
    settle();
    write_reg(CFG_LINE_PITCH, pitch);
    write_reg(CFG_SCREEN_WIDTH, {3'd0, w});
    write_reg(CFG_SCREEN_HEIGHT, {3'd0, h});
    cfg_valid <= 1'b0;
  endtask

  // header plus skip gap plus padded rows, random bytes everywhere else
  task automatic build_bmp(input logic [31:0] ofs, input logic [31:0] wid,
                           input logic [31:0] hgt, input logic [15:0] depth,
                           input logic [7:0] m0, input logic [7:0] m1);
    int body;
    file_q.delete();
    for (int k = 0; k < HDR_LEN; k++) file_q.push_back(8'($urandom));
    file_q[0] = m0;
    file_q[1] = m1;
    for (int k = 0; k < 4; k++) begin
      file_q[OFS_POS + k] = ofs[8*k +: 8];
      file_q[WID_POS + k] = wid[8*k +: 8];
      file_q[HGT_POS + k] = hgt[8*k +: 8];
    end
    file_q[BPP_POS] = depth[7:0];
    file_q[BPP_POS + 1] = depth[15:8];
    body = 0;
    if (wid >= 1 && wid <= MAX_DIM_DEF && hgt >= 1 && hgt <= MAX_DIM_DEF &&
        ofs <= MAX_DATA_OFFSET_DEF) begin
      body = ((int'(wid) * 3 + 3) & ~3) * int'(hgt);
      if (ofs > HDR_LEN) body += int'(ofs) - HDR_LEN;
    end
    for (int k = 0; k < body; k++) file_q.push_back(8'($urandom));
  endtask

  // send the first keep bytes, some trailing bytes, then end of stream
  task automatic send_file(input int keep, input int noise);
    int n;
    n = (keep < file_q.size()) ? keep : file_q.size();
    for (int k = 0; k < n; k++) put_word(1'b0, file_q[k]);
    counted += n;
    repeat (noise) put_word(1'b0, 8'($urandom));
    put_word(1'b1, 8'($urandom));
  endtask

  task automatic send_bmp(input logic [31:0] ofs, input logic [31:0] wid,
                          input logic [31:0] hgt, input logic [15:0] depth,
                          input logic [7:0] m0, input logic [7:0] m1);
    build_bmp(ofs, wid, hgt, depth, m0, m1);
    send_file(file_q.size(), 0);
  endtask

  initial begin : stimulus
    int          pick;
    int          nfile;
    logic [31:0] wid;
    logic [31:0] hgt;
    logic [31:0] ofs;
    logic [15:0] depth;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    calm = 1'b0;
    counted = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // end of stream before any byte
    put_word(1'b1, 8'hFF);
    // header errors, check order included
    send_bmp(32'd54, 32'd2, 32'd2, BPP_24, CH_B, 8'h58);
    send_bmp(32'd54, 32'd2, 32'd2, 16'd32, 8'h00, CH_M);
    send_bmp(32'd54, 32'd2, 32'd2, 16'd32, CH_B, CH_M);
    send_bmp(32'd54, 32'd0, 32'd2, 16'd8, CH_B, CH_M);
    send_bmp(32'd54, 32'd0, 32'd3, BPP_24, CH_B, CH_M);
    send_bmp(32'd54, 32'hFFFF_FFFF, 32'd1, BPP_24, CH_B, CH_M);
    send_bmp(32'd54, 32'd2, 32'd4097, BPP_24, CH_B, CH_M);
    send_bmp(32'd65536, 32'd1, 32'd1, BPP_24, CH_B, CH_M);
    // offset below the header, skipped offset, bytes after done
    send_bmp(32'd0, 32'd2, 32'd2, BPP_24, CH_B, CH_M);
    build_bmp(32'd60, 32'd3, 32'd2, BPP_24, CH_B, CH_M);
    send_file(file_q.size(), 5);
    // last byte of the last row also closes a pixel, then a padded row
    send_bmp(32'd54, 32'd4, 32'd1, BPP_24, CH_B, CH_M);
    send_bmp(32'd54, 32'd1, 32'd1, BPP_24, CH_B, CH_M);
    // cut in the header, the skip gap and the pixels
    build_bmp(32'd58, 32'd2, 32'd2, BPP_24, CH_B, CH_M);
    send_file(20, 0);
    send_file(56, 0);
    send_file(62, 0);

    set_screen(16'd4, 13'd1, 13'd1);
    send_bmp(32'd54, 32'd3, 32'd3, BPP_24, CH_B, CH_M);
    send_bmp(32'd54, 32'd1, 32'd1, BPP_24, CH_B, CH_M);

    set_screen(16'd24, 13'd8, 13'd6);
    send_bmp(32'd54, 32'd4, 32'd6, BPP_24, CH_B, CH_M);
    send_bmp(32'd54, 32'd5, 32'd3, BPP_24, CH_B, CH_M);
    send_bmp(32'd54, 32'd9, 32'd2, BPP_24, CH_B, CH_M);

    // largest sizes and offset, each file cut short
    set_screen(16'd65535, 13'd4096, 13'd4096);
    build_bmp(32'd54, 32'd1, 32'd4096, BPP_24, CH_B, CH_M);
    send_file(HDR_LEN + 12, 0);
    build_bmp(32'd54, 32'd4096, 32'd1, BPP_24, CH_B, CH_M);
    send_file(HDR_LEN + 24, 0);
    build_bmp(32'd65535, 32'd1, 32'd1, BPP_24, CH_B, CH_M);
    send_file(HDR_LEN + 8, 0);

    counted = 0;
    nfile = 0;
    while (counted < 500) begin
      if (nfile % 5 == 0) begin
        if ($urandom_range(0, 3) == 0)
          set_screen(16'($urandom_range(4, 65535)), 13'($urandom_range(1, 4096)),
                     13'($urandom_range(1, 4096)));
        else
          set_screen(16'($urandom_range(4, 65535)), 13'($urandom_range(1, 12)),
                     13'($urandom_range(1, 12)));
      end
      nfile++;
      calm = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 9);
      wid = $urandom_range(1, 6);
      hgt = $urandom_range(1, 5);
      ofs = $urandom_range(0, 1) ? $urandom_range(0, 54) : $urandom_range(55, 62);
      depth = BPP_24;
      if (pick < 6) begin
        build_bmp(ofs, wid, hgt, depth, CH_B, CH_M);
        send_file(file_q.size(), $urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
      end else if (pick < 8) begin
        build_bmp(ofs, wid, hgt, depth, CH_B, CH_M);
        send_file($urandom_range(0, file_q.size() - 1), 0);
      end else if (pick == 8) begin
        case ($urandom_range(0, 4))
          0: begin
            build_bmp(ofs, wid, hgt, depth, 8'($urandom), 8'($urandom));
          end
          1: begin
            build_bmp(ofs, wid, hgt, 16'($urandom), CH_B, CH_M);
          end
          2: begin
            wid = $urandom_range(0, 1) ? 32'd0 - $urandom_range(0, 9)
                                       : 32'd4097 + $urandom_range(0, 100000);
            build_bmp(ofs, wid, hgt, depth, CH_B, CH_M);
          end
          3: begin
            hgt = $urandom_range(0, 1) ? 32'd0 - $urandom_range(0, 9)
                                       : 32'd4097 + $urandom_range(0, 100000);
            build_bmp(ofs, wid, hgt, depth, CH_B, CH_M);
          end
          default: begin
            ofs = {16'($urandom_range(1, 65535)), 16'($urandom)};
            build_bmp(ofs, wid, hgt, depth, CH_B, CH_M);
          end
        endcase
        send_file(file_q.size(), 0);
      end else begin
        file_q.delete();
        repeat ($urandom_range(0, 80)) file_q.push_back(8'($urandom));
        if (file_q.size() > 1 && $urandom_range(0, 1)) begin
          file_q[0] = CH_B;
          file_q[1] = CH_M;
        end
        send_file(file_q.size(), 0);
      end
    end

    calm = 1'b0;
    settle();
    repeat (8) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
